// File: design/radix_page_table_walker_top_assert.svh
// ----------------------------------------------------------------------------
// radix page table walker assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RADIX_PAGE_TABLE_WALKER_TOP_ASSERT_SVH
`define RADIX_PAGE_TABLE_WALKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RPTW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rptw assertion failed");

// next-cycle implication
`define RPTW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rptw assertion failed");

`else

`define RPTW_ASSERT_IMPL(label, ante, cons)
`define RPTW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: design/rptw_pkg.sv
// ----------------------------------------------------------------------------
// rptw_pkg
// shared widths, codes and transaction types of the radix page table walker
// ----------------------------------------------------------------------------
package rptw_pkg;

  // field widths
  localparam int unsigned TASK_W    = 32;
  localparam int unsigned VADDR_W   = 64;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned RADDR_W   = 44;
  localparam int unsigned RBYTES_W  = 4;
  localparam int unsigned PADDR_W   = 43;
  localparam int unsigned RUN_W     = 13;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // table geometry
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned IDX_BITS   = 10;
  localparam int unsigned PFN_W      = 31;
  localparam int unsigned ENTRY_W    = 32;

  localparam int unsigned DEFAULT_MAX_LEVELS = 4;

  // input commands
  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_RESPONSE  = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_READ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FAIL = 2'd2;

  // read sizes
  localparam logic [RBYTES_W-1:0] BYTES_HEADER = 4'd8;
  localparam logic [RBYTES_W-1:0] BYTES_ENTRY  = 4'd4;

  // walk phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_ENTRY  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TASK_NUMBER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_PAGE   = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [TASK_W-1:0]  task_id;
    logic [VADDR_W-1:0] virt_addr;
    logic [DATA_W-1:0]  read_data;
    logic               read_ok;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [RADDR_W-1:0]  read_addr;
    logic [RBYTES_W-1:0] read_bytes;
    logic [PADDR_W-1:0]  phys_addr;
    logic [RUN_W-1:0]    run_length;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

  typedef struct packed {
    logic [1:0] phase;
  } walk_status_t;

endpackage

// File: design/rptw_if.sv
// ----------------------------------------------------------------------------
// rptw channel interfaces
// valid/ready channels for walker requests and walker results
// ----------------------------------------------------------------------------
interface rptw_in_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [rptw_pkg::TASK_W-1:0]    task_id;
  logic [rptw_pkg::VADDR_W-1:0]   virt_addr;
  logic [rptw_pkg::DATA_W-1:0]    read_data;
  logic                           read_ok;

  modport source (output valid, cmd, task_id, virt_addr, read_data, read_ok, input ready);
  modport sink   (input valid, cmd, task_id, virt_addr, read_data, read_ok, output ready);
endinterface

interface rptw_out_if;
  logic                           valid;
  logic                           ready;
  logic [rptw_pkg::KIND_W-1:0]    kind;
  logic [rptw_pkg::RADDR_W-1:0]   read_addr;
  logic [rptw_pkg::RBYTES_W-1:0]  read_bytes;
  logic [rptw_pkg::PADDR_W-1:0]   phys_addr;
  logic [rptw_pkg::RUN_W-1:0]     run_length;

  modport source (output valid, kind, read_addr, read_bytes, phys_addr, run_length,
                  input ready);
  modport sink   (input valid, kind, read_addr, read_bytes, phys_addr, run_length,
                  output ready);
endinterface

// File: design/rptw_step.sv
// ----------------------------------------------------------------------------
// rptw_step
// walk state and the one-step decision for each registered transaction
// ----------------------------------------------------------------------------
module rptw_step #(
  parameter int unsigned MAX_LEVELS = rptw_pkg::DEFAULT_MAX_LEVELS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  rptw_pkg::in_item_t           item,
  input  logic [rptw_pkg::TASK_W-1:0]  task_number,
  input  logic [rptw_pkg::CFG_W-1:0]   root_page,
  output rptw_pkg::step_res_t          res,
  output rptw_pkg::walk_status_t       status
);

  localparam int unsigned PIDX_W = MAX_LEVELS * rptw_pkg::IDX_BITS;
  localparam int unsigned LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned OFF_W  = rptw_pkg::PAGE_SHIFT;

  logic [1:0]        phase_r, phase_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [PIDX_W-1:0] pidx_r, pidx_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;

  logic [rptw_pkg::ENTRY_W-1:0]  first_page;
  logic [rptw_pkg::ENTRY_W-1:0]  levels;
  logic [rptw_pkg::ENTRY_W-1:0]  levels_m1;
  logic [rptw_pkg::ENTRY_W-1:0]  pte;
  logic [LVL_W-1:0]              sel_lvl;
  logic [rptw_pkg::IDX_BITS-1:0] idx;
  logic                          hdr_bad;

  // header and entry fields
  assign first_page = item.read_data[rptw_pkg::ENTRY_W-1:0];
  assign levels     = item.read_data[rptw_pkg::DATA_W-1:rptw_pkg::ENTRY_W];
  assign levels_m1  = levels - 32'd1;
  assign pte        = item.read_data[rptw_pkg::ENTRY_W-1:0];
  assign hdr_bad    = !item.read_ok || (first_page == '0) || (levels == '0) ||
                      (levels > rptw_pkg::ENTRY_W'(MAX_LEVELS));

  // level whose index selects the next entry
  assign sel_lvl = (phase_r == rptw_pkg::PH_HEADER) ? levels_m1[LVL_W-1:0]
                                                    : level_r - LVL_W'(1);
  assign idx     = pidx_r[int'(sel_lvl) * rptw_pkg::IDX_BITS +: rptw_pkg::IDX_BITS];

  // step decision
  always_comb begin
    phase_nxt = phase_r;
    level_nxt = level_r;
    pidx_nxt  = pidx_r;
    off_nxt   = off_r;
    res       = '0;
    if (item.cmd == rptw_pkg::CMD_TRANSLATE) begin
      res.valid = 1'b1;
      phase_nxt = rptw_pkg::PH_IDLE;
      if ((item.task_id != task_number) || (root_page == '0)) begin
        res.item.kind = rptw_pkg::KIND_FAIL;
      end else begin
        pidx_nxt  = item.virt_addr[rptw_pkg::PAGE_SHIFT +: PIDX_W];
        off_nxt   = item.virt_addr[OFF_W-1:0];
        phase_nxt = rptw_pkg::PH_HEADER;
        res.item.kind       = rptw_pkg::KIND_READ;
        res.item.read_addr  = {root_page, {OFF_W{1'b0}}};
        res.item.read_bytes = rptw_pkg::BYTES_HEADER;
      end
    end else begin
      case (phase_r)
        rptw_pkg::PH_HEADER: begin
          res.valid = 1'b1;
          if (hdr_bad) begin
            phase_nxt     = rptw_pkg::PH_IDLE;
            res.item.kind = rptw_pkg::KIND_FAIL;
          end else begin
            level_nxt = sel_lvl;
            phase_nxt = rptw_pkg::PH_ENTRY;
            res.item.kind       = rptw_pkg::KIND_READ;
            res.item.read_addr  = {first_page, idx, 2'b00};
            res.item.read_bytes = rptw_pkg::BYTES_ENTRY;
          end
        end
        rptw_pkg::PH_ENTRY: begin
          res.valid = 1'b1;
          if (!item.read_ok || (pte == '0)) begin
            phase_nxt     = rptw_pkg::PH_IDLE;
            res.item.kind = rptw_pkg::KIND_FAIL;
          end else if (level_r == '0) begin
            // leaf: data page plus offset, run to page end
            phase_nxt           = rptw_pkg::PH_IDLE;
            res.item.kind       = rptw_pkg::KIND_OK;
            res.item.phys_addr  = {pte[rptw_pkg::PFN_W-1:0], off_r};
            res.item.run_length = 13'h1000 - {1'b0, off_r};
          end else begin
            level_nxt = sel_lvl;
            res.item.kind       = rptw_pkg::KIND_READ;
            res.item.read_addr  = {1'b0, pte[rptw_pkg::PFN_W-1:0], idx, 2'b00};
            res.item.read_bytes = rptw_pkg::BYTES_ENTRY;
          end
        end
        default: begin
          // response with no walk in progress is dropped
        end
      endcase
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rptw_pkg::PH_IDLE;
      level_r <= '0;
      pidx_r  <= '0;
      off_r   <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      level_r <= level_nxt;
      pidx_r  <= pidx_nxt;
      off_r   <= off_nxt;
    end
  end

  assign status.phase = phase_r;

endmodule

// File: design/radix_page_table_walker_top.sv
// ----------------------------------------------------------------------------
// radix_page_table_walker_top
// page table walker for one configured task, memory reads issued as results
// ----------------------------------------------------------------------------
// Usage: in_chan carries translate requests (cmd 0: task_id, virt_addr) and
// memory read responses (cmd 1: read_data, read_ok). out_chan carries read
// requests (kind 0), finished translations (kind 1) and failures (kind 2).
// A translate asks for the header, each response asks for the next entry,
// and the leaf response gives phys_addr and run_length. A response with no
// walk in progress gives no result. cfg_we writes task_number (index 0) or
// root_page_number (index 1); write them only while no walk is pending.
// An accepted transaction passes through the input register, the decision
// step and the result register before it is shown on out_chan.
// Throughput: one transaction per cycle while out_chan does not stall, set
// by the single decision step between the two registers; a walk of N levels
// takes N+1 round trips through the memory behind out_chan.
// Reset clears the walk, both configuration registers and both channels.
// When out_chan stalls, the result register holds, the input register keeps
// one transaction, and in_chan.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`include "radix_page_table_walker_top_assert.svh"

module radix_page_table_walker_top #(
  parameter int unsigned MAX_LEVELS = rptw_pkg::DEFAULT_MAX_LEVELS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rptw_in_if.sink                         in_chan,
  rptw_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [rptw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rptw_pkg::CFG_W-1:0]      cfg_wdata
);

  logic                          in_valid_r;
  rptw_pkg::in_item_t            in_item_r;
  logic                          out_valid_r;
  rptw_pkg::out_item_t           out_item_r;
  logic [rptw_pkg::TASK_W-1:0]   task_number_r;
  logic [rptw_pkg::CFG_W-1:0]    root_page_r;
  logic                          out_free;
  logic                          adv;
  logic                          in_accept;
  rptw_pkg::step_res_t           res;
  rptw_pkg::walk_status_t        status;

  // handshake control
  assign out_free      = !out_valid_r || out_chan.ready;
  assign adv           = in_valid_r && out_free;
  assign in_chan.ready = !in_valid_r || adv;
  assign in_accept     = in_chan.valid && in_chan.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_number_r <= '0;
      root_page_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rptw_pkg::REG_TASK_NUMBER: task_number_r <= cfg_wdata;
        rptw_pkg::REG_ROOT_PAGE:   root_page_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r.cmd       <= in_chan.cmd;
      in_item_r.task_id   <= in_chan.task_id;
      in_item_r.virt_addr <= in_chan.virt_addr;
      in_item_r.read_data <= in_chan.read_data;
      in_item_r.read_ok   <= in_chan.read_ok;
    end
  end

  // decision step and walk state
  rptw_step #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .item        (in_item_r),
    .task_number (task_number_r),
    .root_page   (root_page_r),
    .res         (res),
    .status      (status)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= adv && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_item_r <= res.item;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.kind       = out_item_r.kind;
  assign out_chan.read_addr  = out_item_r.read_addr;
  assign out_chan.read_bytes = out_item_r.read_bytes;
  assign out_chan.phys_addr  = out_item_r.phys_addr;
  assign out_chan.run_length = out_item_r.run_length;

  // checks
  `RPTW_ASSERT_IMPL(a_ready_only_on_stall, !in_chan.ready, out_valid_r && !out_chan.ready)
  `RPTW_ASSERT_NEXT(a_header_req_sets_phase,
                    adv && res.valid && res.item.kind == rptw_pkg::KIND_READ &&
                    res.item.read_bytes == rptw_pkg::BYTES_HEADER,
                    status.phase == rptw_pkg::PH_HEADER)
  `RPTW_ASSERT_NEXT(a_done_returns_idle,
                    adv && res.valid && res.item.kind != rptw_pkg::KIND_READ,
                    status.phase == rptw_pkg::PH_IDLE)

endmodule

// File: test/radix_page_table_walker_top_tb.sv
// ----------------------------------------------------------------------------
// radix_page_table_walker_top_tb
// Drives translate requests and memory responses into the walker and acts
// as the memory behind it. Every accepted transaction goes through a
// cycle-free walker predictor. Each result read, header read, entry read,
// finished or failed translation is compared field by field with the oldest
// pending prediction. Directed walks come first, then random walks under
// several task and root settings, with random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module radix_page_table_walker_top_tb;

  localparam int unsigned WALK_LEVELS  = rptw_pkg::DEFAULT_MAX_LEVELS;
  localparam int          IDLE_LIMIT   = 5000;
  localparam int          MAX_REPORTS  = 30;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [rptw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rptw_pkg::CFG_W-1:0]     cfg_wdata;

  rptw_in_if  in_ch ();
  rptw_out_if out_ch ();

  radix_page_table_walker_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // predicted walker state and configuration
  logic [31:0] walk_task;
  logic [31:0] walk_root;
  logic [1:0]  walk_phase;
  int          walk_shift;
  logic [39:0] walk_index;
  logic [11:0] walk_offset;

  rptw_pkg::out_item_t pending_results[$];

  int error_count;
  int results_predicted;
  int reads_seen;
  int translations_seen;
  int failures_seen;
  int settings_used;
  int burst_left;
  int idle_cycles;
  int stall_mode;
  int stall_left;
  int stall_tick;

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------

  // entry read of one node page at the current index shift
  function automatic rptw_pkg::out_item_t entry_read(input logic [31:0] page);
    rptw_pkg::out_item_t r;
    logic [9:0] idx;
    r = '0;
    idx = walk_index[walk_shift +: 10];
    r.kind       = rptw_pkg::KIND_READ;
    r.read_addr  = {page, idx, 2'b00};
    r.read_bytes = rptw_pkg::BYTES_ENTRY;
    return r;
  endfunction

  task automatic predict_walk_step(input rptw_pkg::in_item_t it);
    rptw_pkg::out_item_t res;
    logic [31:0]         first;
    logic [31:0]         levels;
    logic [31:0]         pte;
    bit                  has_res;
    res = '0;
    res.kind = rptw_pkg::KIND_FAIL;
    has_res = 1'b1;
    if (it.cmd == rptw_pkg::CMD_TRANSLATE) begin
      // a translate always drops any walk in progress
      walk_phase = rptw_pkg::PH_IDLE;
      if (it.task_id == walk_task && walk_root != 32'd0) begin
        walk_index  = it.virt_addr[51:12];
        walk_offset = it.virt_addr[11:0];
        walk_phase  = rptw_pkg::PH_HEADER;
        res.kind       = rptw_pkg::KIND_READ;
        res.read_addr  = {walk_root, 12'h000};
        res.read_bytes = rptw_pkg::BYTES_HEADER;
      end
    end else if (walk_phase == rptw_pkg::PH_HEADER) begin
      first  = it.read_data[31:0];
      levels = it.read_data[63:32];
      if (!it.read_ok || first == 32'd0 || levels == 32'd0 || levels > WALK_LEVELS) begin
        walk_phase = rptw_pkg::PH_IDLE;
      end else begin
        // first level uses the full 32-bit page number
        walk_shift = (int'(levels) - 1) * rptw_pkg::IDX_BITS;
        res = entry_read(first);
        walk_phase = rptw_pkg::PH_ENTRY;
      end
    end else if (walk_phase == rptw_pkg::PH_ENTRY) begin
      pte = it.read_data[31:0];
      if (!it.read_ok || pte == 32'd0) begin
        walk_phase = rptw_pkg::PH_IDLE;
      end else if (walk_shift == 0) begin
        // leaf: data page plus offset, run to end of page
        res.kind       = rptw_pkg::KIND_OK;
        res.phys_addr  = {pte[30:0], 12'h000} + rptw_pkg::PADDR_W'(walk_offset);
        res.run_length = 13'h1000 - rptw_pkg::RUN_W'(walk_offset);
        walk_phase = rptw_pkg::PH_IDLE;
      end else begin
        // interior: leaf flag bit dropped from the next page
        walk_shift = walk_shift - rptw_pkg::IDX_BITS;
        res = entry_read({1'b0, pte[30:0]});
      end
    end else begin
      has_res = 1'b0;
    end
    if (has_res) begin
      pending_results.push_back(res);
      results_predicted++;
    end
  endtask

  // ------------------------------------------------------------------
  // reporting and monitors
  // ------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // accepted request and response transactions feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      predict_walk_step({in_ch.cmd, in_ch.task_id, in_ch.virt_addr,
                         in_ch.read_data, in_ch.read_ok});
  end

  // accepted result transactions checked against the oldest prediction
  always @(posedge clk) begin
    rptw_pkg::out_item_t got;
    rptw_pkg::out_item_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.kind, out_ch.read_addr, out_ch.read_bytes,
             out_ch.phys_addr, out_ch.run_length};
      case (got.kind)
        rptw_pkg::KIND_READ: reads_seen++;
        rptw_pkg::KIND_OK:   translations_seen++;
        default:             failures_seen++;
      endcase
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result kind %0d with none pending", got.kind));
      end else begin
        exp_res = pending_results.pop_front();
        if (got.kind != exp_res.kind)
          report_mismatch($sformatf("kind %0d, predicted %0d", got.kind, exp_res.kind));
        if (got.read_addr != exp_res.read_addr)
          report_mismatch($sformatf("read_addr %h, predicted %h",
                                    got.read_addr, exp_res.read_addr));
        if (got.read_bytes != exp_res.read_bytes)
          report_mismatch($sformatf("read_bytes %0d, predicted %0d",
                                    got.read_bytes, exp_res.read_bytes));
        if (got.phys_addr != exp_res.phys_addr)
          report_mismatch($sformatf("phys_addr %h, predicted %h",
                                    got.phys_addr, exp_res.phys_addr));
        if (got.run_length != exp_res.run_length)
          report_mismatch($sformatf("run_length %0d, predicted %0d",
                                    got.run_length, exp_res.run_length));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] timeout: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result receiver stalls, with a stall pattern chosen at random
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
      2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= ((stall_tick % 7) < 4);
    endcase
  end

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------

  // one transaction in, sent in bursts with random gaps
  task automatic issue_walk_item(input rptw_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= it.cmd;
    in_ch.task_id   <= it.task_id;
    in_ch.virt_addr <= it.virt_addr;
    in_ch.read_data <= it.read_data;
    in_ch.read_ok   <= it.read_ok;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // translate with random unused fields
  task automatic issue_translate(input logic [31:0] tid, input logic [63:0] vaddr);
    issue_walk_item({rptw_pkg::CMD_TRANSLATE, tid, vaddr, {$urandom, $urandom},
                     1'($urandom_range(0, 1))});
  endtask

  // memory response with random unused fields
  task automatic issue_response(input logic [63:0] data, input logic ok);
    issue_walk_item({rptw_pkg::CMD_RESPONSE, 32'($urandom), {$urandom, $urandom},
                     data, ok});
  endtask

  // sometimes behave like a slow memory and wait for the read request
  task automatic maybe_wait_memory();
    if ($urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  // bring the walker to idle with no result outstanding
  task automatic settle_walker();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    if (walk_phase != rptw_pkg::PH_IDLE) begin
      // a failed read ends any open walk
      issue_response({$urandom, $urandom}, 1'b0);
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_walker_reg(input logic [rptw_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == rptw_pkg::REG_TASK_NUMBER)
      walk_task = value;
    else
      walk_root = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_walker_context(input logic [31:0] tid, input logic [31:0] root);
    settle_walker();
    write_walker_reg(rptw_pkg::REG_TASK_NUMBER, tid);
    write_walker_reg(rptw_pkg::REG_ROOT_PAGE, root);
    settings_used++;
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // registers clear on reset: no root, so every translate fails
  task automatic test_reset_defaults();
    issue_translate(32'd0, 64'h0000_0000_0000_1234);
    issue_response(64'h0000_0001_0000_0001, 1'b1);  // idle, ignored
    issue_translate(32'hffff_ffff, {64{1'b1}});
  endtask

  // wrong task and zero root
  task automatic test_rejects();
    set_walker_context(32'hffff_ffff, 32'hffff_ffff);
    issue_translate(32'h7fff_ffff, 64'h0);
    issue_response({64{1'b1}}, 1'b1);               // idle, ignored
    set_walker_context(32'h0000_0000, 32'h0000_0000);
    issue_translate(32'h0, {64{1'b1}});
  endtask

  // header checks: failed read, zero page, zero levels, too many levels
  task automatic test_header_checks();
    set_walker_context(32'hffff_ffff, 32'hffff_ffff);
    issue_translate(32'hffff_ffff, 64'h0);
    issue_response(64'h0000_0001_0000_0001, 1'b0);
    issue_translate(32'hffff_ffff, 64'h0);
    issue_response(64'h0000_0002_0000_0000, 1'b1);
    issue_translate(32'hffff_ffff, 64'h0);
    issue_response(64'h0000_0000_0000_0005, 1'b1);
    issue_translate(32'hffff_ffff, 64'h0);
    issue_response({32'd5, 32'h1234_5678}, 1'b1);
    issue_translate(32'hffff_ffff, 64'h0);
    issue_response({32'hffff_ffff, 32'hffff_ffff}, 1'b1);
  endtask

  // entry checks: failed read and zero entry
  task automatic test_entry_checks();
    issue_translate(32'hffff_ffff, 64'h0123_4567_89ab_cdef);
    issue_response({32'd1, 32'h0000_0001}, 1'b1);
    issue_response(64'hffff_ffff_7fff_ffff, 1'b0);
    issue_translate(32'hffff_ffff, 64'h0123_4567_89ab_cdef);
    issue_response({32'd2, 32'h0000_0002}, 1'b1);
    issue_response(64'hffff_ffff_0000_0000, 1'b1);
  endtask

  // full walks at the extremes: four levels, all-ones address, leaf flag set
  task automatic test_full_walks();
    issue_translate(32'hffff_ffff, {64{1'b1}});
    issue_response({32'd4, 32'hffff_ffff}, 1'b1);
    repeat (3) issue_response(64'hffff_ffff_ffff_ffff, 1'b1);
    issue_response(64'h0000_0000_8000_0001, 1'b1);
    // one level, page offset zero gives a full page run
    issue_translate(32'hffff_ffff, 64'h0000_0000_0000_0000);
    issue_response({32'd1, 32'h0000_0001}, 1'b1);
    issue_response(64'h0000_0000_7fff_ffff, 1'b1);
  endtask

  // a translate mid-walk restarts from the header
  task automatic test_walk_restart();
    issue_translate(32'hffff_ffff, 64'h0000_0000_0040_0800);
    issue_response({32'd3, 32'h0000_0010}, 1'b1);
    issue_translate(32'hffff_ffff, 64'h0000_0000_0000_0fff);
    issue_response({32'd1, 32'h0000_0020}, 1'b1);
    issue_response(64'h0000_0000_0000_0030, 1'b1);
  endtask

  // random walks, mostly well formed, with broken and stray transactions
  task automatic test_random_walks(input int target);
    int          start;
    int          levels;
    int          i;
    logic [31:0] tid;
    logic [31:0] first;
    logic [31:0] hdr_levels;
    logic [31:0] pte;
    logic        ok;
    start = results_predicted;
    while (results_predicted - start < target) begin
      tid = ($urandom_range(0, 19) == 0) ? 32'($urandom) : walk_task;
      issue_translate(tid, {$urandom, $urandom});
      maybe_wait_memory();
      levels     = $urandom_range(1, WALK_LEVELS);
      first      = $urandom;
      hdr_levels = levels;
      ok         = 1'b1;
      case ($urandom_range(0, 39))
        0:       first = 32'd0;
        1:       hdr_levels = 32'd0;
        2:       hdr_levels = $urandom_range(WALK_LEVELS + 1, WALK_LEVELS + 3);
        3:       hdr_levels = $urandom;
        4:       ok = 1'b0;
        default: ;
      endcase
      issue_response({hdr_levels, first}, ok);
      for (i = 0; i < levels; i++) begin
        maybe_wait_memory();
        pte = $urandom;
        ok  = 1'b1;
        case ($urandom_range(0, 59))
          0:       pte = 32'd0;
          1:       ok = 1'b0;
          2:       issue_translate(walk_task, {$urandom, $urandom});
          default: ;
        endcase
        issue_response({32'($urandom), pte}, ok);
      end
      // stray response after the walk
      if ($urandom_range(0, 15) == 0)
        issue_response({$urandom, $urandom}, 1'($urandom_range(0, 1)));
    end
  endtask

  // ------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = rptw_pkg::CMD_TRANSLATE;
    in_ch.task_id   = '0;
    in_ch.virt_addr = '0;
    in_ch.read_data = '0;
    in_ch.read_ok   = 1'b0;
    out_ch.ready    = 1'b0;
    walk_task       = '0;
    walk_root       = '0;
    walk_phase      = rptw_pkg::PH_IDLE;
    walk_shift      = 0;
    walk_index      = '0;
    walk_offset     = '0;
    error_count       = 0;
    results_predicted = 0;
    reads_seen        = 0;
    translations_seen = 0;
    failures_seen     = 0;
    settings_used     = 0;
    burst_left        = 0;
    idle_cycles       = 0;
    stall_mode        = 0;
    stall_left        = 0;
    stall_tick        = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_rejects();
    test_header_checks();
    test_entry_checks();
    test_full_walks();
    test_walk_restart();

    set_walker_context(32'h0000_0000, 32'h0000_0001);
    test_random_walks(230);
    set_walker_context(32'hffff_ffff, 32'hffff_ffff);
    test_random_walks(230);
    set_walker_context($urandom, 32'($urandom) | 32'd1);
    test_random_walks(230);
    set_walker_context($urandom, 32'h0000_0000);
    test_random_walks(10);
    set_walker_context($urandom, $urandom_range(1, 255));
    test_random_walks(200);

    // wait out the last results, then watch for stray ones
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("run covered %0d results over %0d task/root settings", results_predicted,
             settings_used);
    $display("  %0d memory reads, %0d translations done, %0d failed", reads_seen,
             translations_seen, failures_seen);
    if (error_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: radix_page_table_walker_top.f
+incdir+design
design/rptw_pkg.sv
design/rptw_if.sv
design/rptw_step.sv
design/radix_page_table_walker_top.sv
test/radix_page_table_walker_top_tb.sv
